### hw/rtl/lru_pr_pkg.sv
// LRU page replacement: shared sizes and the cell control word.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package lru_pr_pkg;

  // Number of physical frames that the recency chain can track
  localparam int MAX_FRAMES = 64;
  // Width of a frame number word
  localparam int FRAME_W    = 6;
  // Tracked count holds 0..MAX_FRAMES
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  // Levels of the match prefix-OR network
  localparam int PFX_LVLS   = $clog2(MAX_FRAMES);

  // Per-cell control from the sequencer
  typedef struct packed {
    logic               capture;    // latch compare result for a new word
    logic [FRAME_W-1:0] cmp_frame;  // frame being looked up
    logic               occupied;   // cell lies below the tracked count
    logic               shift;      // take the neighbor's frame (toward LRU)
    logic               load;       // take new_frame (new MRU slot)
    logic [FRAME_W-1:0] new_frame;
  } lru_pr_cell_ctl_t;

endpackage

### hw/rtl/lru_pr_in_if.sv
// Input channel interface: reference / evict request words.
// Depends on lru_pr_pkg for the frame width.
`timescale 1ns / 1ps

interface lru_pr_in_if import lru_pr_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FRAME_W-1:0] frame_number;

  modport source (output valid, output kind, output frame_number, input ready);
  modport sink   (input valid, input kind, input frame_number, output ready);
endinterface

### hw/rtl/lru_pr_out_if.sv
// Result channel interface: victim frame and status flags.
// Depends on lru_pr_pkg for the frame width.
`timescale 1ns / 1ps

interface lru_pr_out_if import lru_pr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] victim_frame;
  logic               victim_valid;
  logic               empty_error;

  modport source (output valid, output victim_frame, output victim_valid,
                  output empty_error, input ready);
  modport sink   (input valid, input victim_frame, input victim_valid,
                  input empty_error, output ready);
endinterface

### hw/rtl/lru_page_replacement.sv
// Top level of the exact LRU replacement policy: sequencer over a chain of cells.
// Depends on lru_pr_pkg, lru_pr_in_if, lru_pr_out_if and lru_pr_cell.
//
//   channel   dir  modport  word fields
//   in_chan   in   sink     kind, frame_number
//   out_chan  out  source   victim_frame, victim_valid, empty_error
//
// Each word is accepted in ST_IDLE, where every cell compares its frame in
// parallel at the accept edge, then passes ST_APPLY, where a prefix-OR of the
// matches drives the chain shift and the result word is registered. A new word
// is taken only after the previous word's apply step. rst_n is synchronous: the
// chain is empty and no result is pending after reset; frames in unused cells
// are not cleared. A stalled result holds the apply step until out_chan.ready;
// a new word is still taken while the previous result waits in the output register.
// A frame is present exactly when some occupied cell holds it.
`timescale 1ns / 1ps

module lru_page_replacement import lru_pr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  lru_pr_in_if.sink    in_chan,
  lru_pr_out_if.source out_chan
);

  typedef enum logic {ST_IDLE, ST_APPLY} state_t;

  state_t             state_r;
  logic               kind_r;
  logic [FRAME_W-1:0] frame_r;
  logic [CNT_W-1:0]   count_r;
  logic               out_valid_r;
  logic [FRAME_W-1:0] victim_frame_r;
  logic               victim_valid_r;
  logic               empty_error_r;

  logic [FRAME_W-1:0]   cell_frame [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_match;
  lru_pr_cell_ctl_t     cell_ctl   [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] pfx       [PFX_LVLS+1];
  logic [MAX_FRAMES-1:0] hit_pre;

  logic             in_fire;
  logic             apply_fire;
  logic             any_hit;
  logic             ref_ok;
  logic             has_entries;
  logic             do_ref;
  logic             do_evict;
  logic [CNT_W-1:0] tail;
  logic             tail_ok;

  // Handshake
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign apply_fire    = (state_r == ST_APPLY) && (!out_valid_r || out_chan.ready);

  // Prefix-OR of cell matches: hit_pre[i] set when the match lies at or below i
  always_comb begin
    pfx[0] = cell_match;
    for (int l = 0; l < PFX_LVLS; l++) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (i >= (1 << l)) begin
          pfx[l+1][i] = pfx[l][i] | pfx[l][i-(1<<l)];
        end else begin
          pfx[l+1][i] = pfx[l][i];
        end
      end
    end
  end
  assign hit_pre = pfx[PFX_LVLS];
  assign any_hit = hit_pre[MAX_FRAMES-1];

  // Apply-step decode
  assign ref_ok      = int'(frame_r) < MAX_FRAMES;
  assign has_entries = (count_r != '0);
  assign do_ref      = apply_fire && !kind_r && ref_ok;
  assign do_evict    = apply_fire && kind_r && has_entries;
  assign tail        = any_hit ? (count_r - CNT_W'(1)) : count_r;
  assign tail_ok     = (tail < CNT_W'(MAX_FRAMES));

  // Chain of cells, position 0 is least recent
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    logic [FRAME_W-1:0] nbr;
    logic               load_here;

    if (g < MAX_FRAMES - 1) begin : g_mid
      assign nbr = cell_frame[g+1];
    end else begin : g_end
      assign nbr = cell_frame[g];
    end

    assign load_here            = do_ref && tail_ok && (tail == CNT_W'(g));
    assign cell_ctl[g].capture  = in_fire;
    assign cell_ctl[g].cmp_frame = in_chan.frame_number;
    assign cell_ctl[g].occupied = (CNT_W'(g) < count_r);
    assign cell_ctl[g].load     = load_here;
    assign cell_ctl[g].shift    = (do_ref && hit_pre[g] && !load_here) || do_evict;
    assign cell_ctl[g].new_frame = frame_r;

    lru_pr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl[g]),
      .nbr_frame (nbr),
      .frame_o   (cell_frame[g]),
      .match_o   (cell_match[g])
    );
  end

  // Sequencer, tracked count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply_fire) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (in_fire) begin
        kind_r  <= in_chan.kind;
        frame_r <= in_chan.frame_number;
      end

      if (do_ref && !any_hit && tail_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_evict) begin
        count_r <= count_r - CNT_W'(1);
      end

      if (apply_fire) begin
        out_valid_r    <= 1'b1;
        victim_frame_r <= do_evict ? cell_frame[0] : '0;
        victim_valid_r <= do_evict;
        empty_error_r  <= kind_r && !has_entries;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.victim_frame = victim_frame_r;
  assign out_chan.victim_valid = victim_valid_r;
  assign out_chan.empty_error  = empty_error_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FRAMES))
    else $error("tracked count above chain length");

  a_accept_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_APPLY))
    else $error("accepted word did not reach apply step");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_APPLY))
    else $error("result word raised outside apply step");

  a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_evict |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("eviction did not shrink the chain");

endmodule

### hw/rtl/lru_pr_cell.sv
// One position of the LRU recency chain: holds a frame number and a match flag.
// Depends on lru_pr_pkg for the control word and widths.
`timescale 1ns / 1ps

module lru_pr_cell import lru_pr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lru_pr_cell_ctl_t   ctl,
  input  logic [FRAME_W-1:0] nbr_frame,   // frame of the next more-recent cell
  output logic [FRAME_W-1:0] frame_o,
  output logic               match_o
);

  logic [FRAME_W-1:0] frame_r;
  logic               match_r;

  // Frame slot: new MRU entry wins over a shift from the neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      frame_r <= ctl.new_frame;
    end else if (ctl.shift) begin
      frame_r <= nbr_frame;
    end
  end

  // Lookup result, captured when a word is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.capture) begin
      match_r <= ctl.occupied && (frame_r == ctl.cmp_frame);
    end
  end

  assign frame_o = frame_r;
  assign match_o = match_r;

endmodule
